// File: rtl/gtws_pkg.sv
`default_nettype none
package gtws_pkg;

  localparam int WINDOW_DEF     = 10;
  localparam int COUNT_BITS_DEF = 16;

  localparam int BYTE_W = 8;
  localparam int THR_W  = 6;
  localparam int OUT_W  = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);

  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;

  // Marks produced for one processed byte: at most two pushes into the history.
  typedef struct packed {
    logic push1;
    logic mark1;
    logic push2;
    logic mark2;
    logic last;
  } marks_t;

  typedef struct packed {
    logic [OUT_W-1:0] hit_windows;
    logic [OUT_W-1:0] text_length;
    logic             count_saturated;
  } result_t;

  function automatic logic is_alpha(logic [BYTE_W-1:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_good(logic [BYTE_W-1:0] c);
    return is_alpha(c) || is_digit(c) || is_space(c) || (c == CH_GT);
  endfunction

  function automatic logic mark_of(logic [BYTE_W-1:0] cur, logic [BYTE_W-1:0] nxt,
                                   logic has_third, logic [BYTE_W-1:0] third);
    logic alpha_case;
    logic digit_case;
    alpha_case = (is_alpha(cur) || is_space(cur)) && !is_good(nxt);
    digit_case = is_digit(cur) && !is_good(nxt) && has_third && !is_digit(third);
    return alpha_case || digit_case;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gtws_in_if.sv
`default_nettype none
interface gtws_in_if;
  logic                          valid;
  logic                          ready;
  logic [gtws_pkg::BYTE_W-1:0]   text_byte;
  logic                          is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/gtws_out_if.sv
`default_nettype none
interface gtws_out_if;
  logic                         valid;
  logic                         ready;
  logic [gtws_pkg::OUT_W-1:0]   hit_windows;
  logic [gtws_pkg::OUT_W-1:0]   text_length;
  logic                         count_saturated;

  modport source (output valid, output hit_windows, output text_length,
                  output count_saturated, input ready);
  modport sink   (input valid, input hit_windows, input text_length,
                  input count_saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/gtws_front.sv
`default_nettype none
// Holds the two previous bytes and works out the marks that the current byte settles.
module gtws_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [gtws_pkg::BYTE_W-1:0] text_byte,
  input  wire logic                        is_last,
  output gtws_pkg::marks_t                 marks
);

  logic [gtws_pkg::BYTE_W-1:0] prev2;
  logic [gtws_pkg::BYTE_W-1:0] prev1;
  logic [1:0]                  held;

  always_comb begin
    marks.push1 = held[1];
    marks.mark1 = gtws_pkg::mark_of(prev2, prev1, 1'b1, text_byte);
    marks.push2 = is_last && (held != 2'd0);
    marks.mark2 = gtws_pkg::mark_of(prev1, text_byte, 1'b0, text_byte);
    marks.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 2'd0;
      prev2 <= '0;
      prev1 <= '0;
    end else if (step) begin
      if (is_last) begin
        held  <= 2'd0;
        prev2 <= '0;
        prev1 <= '0;
      end else begin
        prev2 <= prev1;
        prev1 <= text_byte;
        if (!held[1]) begin
          held <= held + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/gtws_count.sv
`default_nettype none
// Mark history with a running window sum, hit counter and length counter.
module gtws_count #(
  parameter int WINDOW     = gtws_pkg::WINDOW_DEF,
  parameter int COUNT_BITS = gtws_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire gtws_pkg::marks_t           marks,
  input  wire logic [gtws_pkg::THR_W-1:0] hit_threshold,
  output gtws_pkg::result_t               result
);

  localparam int SUM_W = $clog2(WINDOW + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] FULL_ONE  = COUNT_BITS'(WINDOW + 1);
  localparam logic [COUNT_BITS-1:0] FULL_TWO  = COUNT_BITS'(WINDOW);

  logic [WINDOW-1:0]     history;
  logic [SUM_W-1:0]      win_sum;
  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] hits;
  logic                  sat;

  logic [WINDOW-1:0]     hist1, history_next;
  logic [SUM_W-1:0]      sum1, win_sum_next;
  logic                  hit_a, hit_b;
  logic [COUNT_BITS:0]   hits_sum;
  logic [COUNT_BITS-1:0] hits_next, pos_next;
  logic                  sat_next;

  always_comb begin
    // First push: mark for the byte two places back.
    hist1 = history;
    sum1  = win_sum;
    if (marks.push1) begin
      hist1 = {history[WINDOW-2:0], marks.mark1};
      sum1  = win_sum + SUM_W'(marks.mark1) - SUM_W'(history[WINDOW-1]);
    end
    hit_a = marks.push1 && (pos >= FULL_ONE) &&
            (gtws_pkg::THR_W'(sum1) > hit_threshold);

    // Second push, only on the last byte: mark for the last but one byte.
    history_next = hist1;
    win_sum_next = sum1;
    if (marks.push2) begin
      history_next = {hist1[WINDOW-2:0], marks.mark2};
      win_sum_next = sum1 + SUM_W'(marks.mark2) - SUM_W'(hist1[WINDOW-1]);
    end
    hit_b = marks.push2 && (pos >= FULL_TWO) &&
            (gtws_pkg::THR_W'(win_sum_next) > hit_threshold);

    hits_sum = {1'b0, hits} + (COUNT_BITS+1)'(hit_a) + (COUNT_BITS+1)'(hit_b);
    sat_next = sat;
    if (hits_sum > {1'b0, CNT_MAX}) begin
      hits_next = CNT_MAX;
      sat_next  = 1'b1;
    end else begin
      hits_next = hits_sum[COUNT_BITS-1:0];
    end

    if (pos == CNT_MAX) begin
      pos_next = pos;
      sat_next = 1'b1;
    end else begin
      pos_next = pos + COUNT_BITS'(1);
    end

    result.hit_windows     = gtws_pkg::OUT_W'(hits_next);
    result.text_length     = gtws_pkg::OUT_W'(pos_next);
    result.count_saturated = sat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      win_sum <= '0;
      pos     <= '0;
      hits    <= '0;
      sat     <= 1'b0;
    end else if (step) begin
      if (marks.last) begin
        history <= '0;
        win_sum <= '0;
        pos     <= '0;
        hits    <= '0;
        sat     <= 1'b0;
      end else begin
        history <= history_next;
        win_sum <= win_sum_next;
        pos     <= pos_next;
        hits    <= hits_next;
        sat     <= sat_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/garbled_text_window_scorer.sv
`default_nettype none
// Garbled text window scorer.
// Text enters on text_in one byte per word, with is_last set on the final byte.
// Each byte is registered on acceptance; a byte other than the last is processed
// in the following cycle, so one word can be accepted in every cycle unless a
// last byte waits in the input register. When the last byte is processed, one
// word is registered and appears on result_out: the number of windows whose
// suspicious-mark count exceeded hit_threshold, the text length and a
// saturation flag. The ratio of hits to length is left to software.
// The result sits in an output register; while it waits, further bytes of the
// next text keep flowing in. Only a second last byte stalls text_in, and only
// until the pending result has been taken.
// Reset clears all text state and sets hit_threshold to 3. hit_threshold is
// written through cfg_wr_en and cfg_wr_data, only while the block is idle: a
// rule for the user that the block itself does not enforce. The new value
// applies to every window completed afterwards. After each result the text
// state returns to its reset value, so the next byte begins a new text.
module garbled_text_window_scorer #(
  parameter int WINDOW     = gtws_pkg::WINDOW_DEF,
  parameter int COUNT_BITS = gtws_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [gtws_pkg::THR_W-1:0] cfg_wr_data,
  gtws_in_if.sink                         text_in,
  gtws_out_if.source                      result_out
);

  // Configuration register.
  logic [gtws_pkg::THR_W-1:0] hit_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold <= gtws_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      hit_threshold <= cfg_wr_data;
    end
  end

  // Input register. A byte moves on unless it is a last byte and the output
  // register still holds a result that is not being taken this cycle.
  logic                        s1_valid;
  logic [gtws_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_last;
  logic                        s1_go;
  logic                        in_take;

  assign s1_go         = s1_valid && (!s1_last || !result_out.valid || result_out.ready);
  assign text_in.ready = !s1_valid || s1_go;
  assign in_take       = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= text_in.text_byte;
      s1_last <= text_in.is_last;
    end
  end

  // Byte classification and marks, then the window and counter state.
  gtws_pkg::marks_t  marks;
  gtws_pkg::result_t result;

  gtws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .text_byte (s1_byte),
    .is_last   (s1_last),
    .marks     (marks)
  );

  gtws_count #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_go),
    .marks         (marks),
    .hit_threshold (hit_threshold),
    .result        (result)
  );

  // Output register.
  logic              out_valid;
  gtws_pkg::result_t out_data;
  logic              out_load;

  assign out_load = s1_go && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.hit_windows     = out_data.hit_windows;
  assign result_out.text_length     = out_data.text_length;
  assign result_out.count_saturated = out_data.count_saturated;

`ifndef NO_ASSERTIONS
  // A byte that is not the last never waits in the input register.
  a_mid_byte_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> s1_go)
    else $error("mid-text byte stalled in input register");

  // A pending result is never overwritten before it has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |-> !out_load)
    else $error("pending result overwritten");

  // Processing a last byte presents a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("last byte processed without result");
`endif

endmodule
`default_nettype wire

// File: tb/garbled_text_window_scorer_tb.sv
module garbled_text_window_scorer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is checked at its default sizes: a window of ten marks and
  // sixteen-bit counters.
  localparam int WIN          = gtws_pkg::WINDOW_DEF;
  localparam int CNT_W        = gtws_pkg::COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_SEGS     = 12;
  localparam int PRESSURE_SEG = 5;
  localparam int SEG_BYTES    = 90;

  // A directed text that mixes every byte class: a high byte, a zero byte,
  // control codes, whitespace, the '>' character, a digit followed by junk
  // and a letter (marked), a digit followed by junk and a digit (not marked),
  // and a digit followed by junk as the final pair, where no third byte exists.
  localparam logic [gtws_pkg::BYTE_W-1:0] MIXED_TEXT [19] = '{
    8'h61, 8'h80, 8'h20, 8'h21, 8'h09, 8'h00, 8'h39, 8'h23, 8'h78, 8'h30,
    8'h24, 8'h35, 8'h3E, 8'h7E, 8'h0D, 8'h7F, 8'h01, 8'h33, 8'h25
  };

  typedef struct packed {
    logic [gtws_pkg::BYTE_W-1:0] ch;
    logic                        last;
  } text_word_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [gtws_pkg::THR_W-1:0] cfg_wr_data;

  gtws_in_if  text_ch ();
  gtws_out_if score_ch ();

  garbled_text_window_scorer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .text_in    (text_ch),
    .result_out (score_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Words waiting to be offered, and the scores that the accepted words imply.
  text_word_t        pending_words [$];
  gtws_pkg::result_t expected_scores [$];
  gtws_pkg::result_t want_score;

  logic byte_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_asked = 0;
  int   hold_granted = 0;
  int   hold_left = 0;
  int   fault_count = 0;

  // Scoring state of the text in progress, kept independently of the block.
  logic [gtws_pkg::BYTE_W-1:0] prev2_ch;
  logic [gtws_pkg::BYTE_W-1:0] prev1_ch;
  int unsigned                 held_chars;
  logic [31:0]                 mark_bits;
  logic [CNT_W-1:0]            chars_seen;
  logic [CNT_W-1:0]            hit_total;
  logic                        sat_seen;
  logic [gtws_pkg::THR_W-1:0]  hit_thr;

  // Byte classes of the C locale. Nothing at or above 128 belongs to any class.
  function automatic bit letter_ch(input logic [gtws_pkg::BYTE_W-1:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic bit digit_ch(input logic [gtws_pkg::BYTE_W-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic bit blank_ch(input logic [gtws_pkg::BYTE_W-1:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic bit clean_ch(input logic [gtws_pkg::BYTE_W-1:0] c);
    return letter_ch(c) || digit_ch(c) || blank_ch(c) || (c == gtws_pkg::CH_GT);
  endfunction

  // A position is suspicious when a letter or blank is followed by junk, or a
  // digit is followed by junk and then by a byte that is present and no digit.
  function automatic bit suspicious(input logic [gtws_pkg::BYTE_W-1:0] cur,
                                    input logic [gtws_pkg::BYTE_W-1:0] nxt,
                                    input bit third_known,
                                    input logic [gtws_pkg::BYTE_W-1:0] third);
    if (clean_ch(nxt))
      return 1'b0;
    if (letter_ch(cur) || blank_ch(cur))
      return 1'b1;
    return digit_ch(cur) && third_known && !digit_ch(third);
  endfunction

  task automatic clear_text_state();
    prev2_ch   = '0;
    prev1_ch   = '0;
    held_chars = 0;
    mark_bits  = '0;
    chars_seen = '0;
    hit_total  = '0;
    sat_seen   = 1'b0;
  endtask

  // Shift one mark into the history and, once a whole window lies behind it,
  // count the window as a hit when its marks outnumber the threshold.
  task automatic record_mark(input bit m, input bit window_done);
    mark_bits = {mark_bits[30:0], m};
    if (window_done && ($countones(mark_bits[WIN-1:0]) > hit_thr)) begin
      if (hit_total == CNT_TOP)
        sat_seen = 1'b1;
      else
        hit_total++;
    end
  endtask

  // Score one accepted word. The mark of a position is settled two bytes
  // later, except for the last-but-one byte, which is settled by the last.
  task automatic absorb_byte(input logic [gtws_pkg::BYTE_W-1:0] c, input logic last);
    int unsigned       idx;
    gtws_pkg::result_t score;
    idx = 32'(chars_seen);
    if (held_chars >= 2)
      record_mark(suspicious(prev2_ch, prev1_ch, 1'b1, c), idx >= WIN + 1);
    prev2_ch = prev1_ch;
    prev1_ch = c;
    if (held_chars < 2)
      held_chars++;
    if (chars_seen == CNT_TOP)
      sat_seen = 1'b1;
    else
      chars_seen++;
    if (last) begin
      if (held_chars >= 2)
        record_mark(suspicious(prev2_ch, c, 1'b0, '0), idx >= WIN);
      score.hit_windows     = gtws_pkg::OUT_W'(hit_total);
      score.text_length     = gtws_pkg::OUT_W'(chars_seen);
      score.count_saturated = sat_seen;
      expected_scores.push_back(score);
      clear_text_state();
    end
  endtask

  // Driver: a new word is offered at the falling edge only once the previous
  // one has been taken, and the sender idles at random as the phase demands.
  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid     <= 1'b0;
      text_ch.text_byte <= '0;
      text_ch.is_last   <= 1'b0;
    end else if (!text_ch.valid || byte_taken) begin
      if ((pending_words.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct)) begin
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= pending_words[0].ch;
        text_ch.is_last   <= pending_words[0].last;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready is dropped at random, and on request it is held low for a
  // long stretch counted here, so that a finished score waits in the block and
  // a second text end backs up the input.
  always @(negedge clk) begin
    if (rst) begin
      score_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      score_ch.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      score_ch.ready <= 1'b0;
      hold_granted   <= hold_asked;
      hold_left      <= HOLD_CYCLES;
    end else begin
      score_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: at each rising edge the accepted input word is scored first, so
  // that the check of an output word never depends on the order of processes.
  always @(posedge clk) begin
    byte_taken <= !rst && text_ch.valid && text_ch.ready;
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) begin
        absorb_byte(text_ch.text_byte, text_ch.is_last);
        void'(pending_words.pop_front());
      end
      if (score_ch.valid && score_ch.ready) begin
        if (expected_scores.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: score word with none expected: hits %0d length %0d sat %0b",
                     $realtime, score_ch.hit_windows, score_ch.text_length,
                     score_ch.count_saturated);
        end else begin
          want_score = expected_scores.pop_front();
          if ((score_ch.hit_windows !== want_score.hit_windows) ||
              (score_ch.text_length !== want_score.text_length) ||
              (score_ch.count_saturated !== want_score.count_saturated)) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: score mismatch: expected hits %0d length %0d sat %0b, got %s",
                       $realtime, want_score.hit_windows, want_score.text_length,
                       want_score.count_saturated,
                       $sformatf("hits %0d length %0d sat %0b", score_ch.hit_windows,
                                 score_ch.text_length, score_ch.count_saturated));
          end
        end
      end
    end
  end

  task automatic put_word(input logic [gtws_pkg::BYTE_W-1:0] c, input logic last);
    text_word_t w;
    w.ch   = c;
    w.last = last;
    pending_words.push_back(w);
  endtask

  // A random byte: junk with the given percentage, otherwise a letter, digit,
  // blank or '>'.
  function automatic logic [gtws_pkg::BYTE_W-1:0] pick_char(input int junk_pct);
    logic [gtws_pkg::BYTE_W-1:0] c;
    if ($urandom_range(0, 99) < junk_pct) begin
      do begin
        case ($urandom_range(0, 2))
          0:       c = gtws_pkg::BYTE_W'($urandom_range(1, 31));
          1:       c = gtws_pkg::BYTE_W'($urandom_range(33, 127));
          default: c = gtws_pkg::BYTE_W'($urandom_range(128, 255));
        endcase
      end while (clean_ch(c));
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    c = gtws_pkg::BYTE_W'($urandom_range(8'h41, 8'h5A));
        2, 3, 4: c = gtws_pkg::BYTE_W'($urandom_range(8'h61, 8'h7A));
        5, 6:    c = gtws_pkg::BYTE_W'($urandom_range(8'h30, 8'h39));
        7:       c = gtws_pkg::BYTE_W'($urandom_range(8'h09, 8'h0D));
        8:       c = gtws_pkg::CH_SPACE;
        default: c = gtws_pkg::CH_GT;
      endcase
    end
    return c;
  endfunction

  // Most texts are short; some are long enough to hold many windows.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return $urandom_range(1, 14);
    if (r < 9)
      return $urandom_range(15, 60);
    return $urandom_range(61, 150);
  endfunction

  // From clean prose to heavily garbled text.
  function automatic int pick_junk();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      3:       return 50;
      default: return 80;
    endcase
  endfunction

  task automatic queue_random_text(input int len, input int junk_pct);
    for (int i = 0; i < len; i++)
      put_word(pick_char(junk_pct), i == len - 1);
  endtask

  // The sender stops until every word has gone and every score has come back,
  // and the block is then left to settle before anything is changed.
  task automatic wait_drained();
    while ((pending_words.size() != 0) || (expected_scores.size() != 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The threshold is written only while the block is idle.
  task automatic set_threshold(input logic [gtws_pkg::THR_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    hit_thr      = v;
    @(posedge clk);
  endtask

  initial begin
    int                         queued;
    int                         len;
    logic [gtws_pkg::THR_W-1:0] thr;

    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst         = 1'b1;
    hit_thr     = gtws_pkg::THR_RESET;
    clear_text_state();

    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // First phase: the sender idles less than the receiver.
    send_idle_pct = 32;
    recv_idle_pct = 46;

    // Directed texts with a threshold of zero, so that any marked window is
    // a hit: a single byte, a two-byte text with a marked letter and a high
    // byte, and the mixed text above.
    set_threshold('0);
    put_word(8'h41, 1'b1);
    put_word(8'h5A, 1'b0);
    put_word(8'hFF, 1'b1);
    foreach (MIXED_TEXT[i])
      put_word(MIXED_TEXT[i], i == $size(MIXED_TEXT) - 1);
    wait_drained();

    // Random texts in segments, each under its own threshold.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 32;
      end
      if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       thr = 6'd1;
        1:       thr = 6'd32;
        6:       thr = '1;
        9:       thr = '0;
        default: thr = gtws_pkg::THR_W'($urandom_range(0, 7));
      endcase
      set_threshold(thr);
      if (seg == PRESSURE_SEG) begin
        // Many tiny texts while the receiver holds off, so that a second
        // text end finds the score register still full.
        hold_asked++;
        repeat (40) queue_random_text($urandom_range(1, 3), 50);
      end else begin
        queued = 0;
        while (queued < SEG_BYTES) begin
          len = pick_length();
          queue_random_text(len, pick_junk());
          queued += len;
        end
      end
      wait_drained();
    end

    if ((fault_count == 0) && (expected_scores.size() == 0))
      $display("garbled_text_window_scorer_tb: clean");
    else
      $display("garbled_text_window_scorer_tb: errors");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("garbled_text_window_scorer_tb: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/gtws_pkg.sv
rtl/gtws_in_if.sv
rtl/gtws_out_if.sv
rtl/gtws_front.sv
rtl/gtws_count.sv
rtl/garbled_text_window_scorer.sv
tb/garbled_text_window_scorer_tb.sv
